>>> src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

>>> src/sdr_pkg.sv
`default_nettype none
package sdr_pkg;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int COORD_IN_W = 12;
  localparam int DISP_W     = 16;
  localparam int Q_W        = 32;
  localparam int PX_W       = 32;
  localparam int PZ_W       = 31;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 96;

  // disparity Q.4 shifted by 4 more bits: 15 magnitude bits + 4
  localparam int DEN_W  = DISP_W - 1 + 4;
  localparam int DENY_W = DEN_W + CFG_W;

  localparam int DEF_COORD_WIDTH    = 12;
  localparam int DEF_DISP_FRAC_BITS = 4;

  localparam logic [CFG_W-1:0] RST_FOCAL_X  = 16'd8000;
  localparam logic [CFG_W-1:0] RST_FOCAL_Y  = 16'd8000;
  localparam logic [CFG_W-1:0] RST_CENTER_X = 16'd5120;
  localparam logic [CFG_W-1:0] RST_CENTER_Y = 16'd3840;
  localparam logic [CFG_W-1:0] RST_BASELINE = 16'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X  = 3'd0,
    CFG_FOCAL_Y  = 3'd1,
    CFG_CENTER_X = 3'd2,
    CFG_CENTER_Y = 3'd3,
    CFG_BASELINE = 3'd4
  } sdr_cfg_idx_t;

  // valid bit and offset signs that ride alongside the datapath
  typedef struct packed {
    logic v;
    logic xn;
    logic yn;
  } sdr_meta_t;

endpackage
`default_nettype wire

>>> src/sdr_prep.sv
`default_nettype none
// Config registers, offsets and the numerator/denominator products.
module sdr_prep #(
  parameter int COORD_WIDTH    = sdr_pkg::DEF_COORD_WIDTH,
  parameter int DISP_FRAC_BITS = sdr_pkg::DEF_DISP_FRAC_BITS,
  parameter int SCALE_W        = sdr_pkg::CFG_W + DISP_FRAC_BITS,
  parameter int NUMZ_W         = SCALE_W + sdr_pkg::CFG_W,
  parameter int NUMY_W         = SCALE_W + 2 * sdr_pkg::CFG_W
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  en,
  input  wire                                  cfg_wr_en,
  input  wire  [sdr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [sdr_pkg::CFG_W-1:0]            cfg_wdata,
  input  wire                                  in_acc,
  input  wire  [sdr_pkg::COORD_IN_W-1:0]       in_column,
  input  wire  [sdr_pkg::COORD_IN_W-1:0]       in_row,
  input  wire  [sdr_pkg::DISP_W-1:0]           in_disparity,
  output sdr_pkg::sdr_meta_t                   meta_o,
  output logic [NUMZ_W-1:0]                    num_z_o,
  output logic [NUMZ_W-1:0]                    num_x_o,
  output logic [NUMY_W-1:0]                    num_y_o,
  output logic [sdr_pkg::DEN_W-1:0]            den_o,
  output logic [sdr_pkg::DENY_W-1:0]           den_y_o
);

  localparam int CW = sdr_pkg::CFG_W;
  localparam logic [sdr_pkg::COORD_IN_W-1:0] CMASK =
    (COORD_WIDTH >= sdr_pkg::COORD_IN_W) ? '1 :
    sdr_pkg::COORD_IN_W'((1 << COORD_WIDTH) - 1);

  logic [CW-1:0] focal_x_r, focal_y_r, center_x_r, center_y_r, baseline_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= sdr_pkg::RST_FOCAL_X;
      focal_y_r  <= sdr_pkg::RST_FOCAL_Y;
      center_x_r <= sdr_pkg::RST_CENTER_X;
      center_y_r <= sdr_pkg::RST_CENTER_Y;
      baseline_r <= sdr_pkg::RST_BASELINE;
    end else if (cfg_wr_en) begin
      case (sdr_pkg::sdr_cfg_idx_t'(cfg_index))
        sdr_pkg::CFG_FOCAL_X:  focal_x_r  <= cfg_wdata;
        sdr_pkg::CFG_FOCAL_Y:  focal_y_r  <= cfg_wdata;
        sdr_pkg::CFG_CENTER_X: center_x_r <= cfg_wdata;
        sdr_pkg::CFG_CENTER_Y: center_y_r <= cfg_wdata;
        sdr_pkg::CFG_BASELINE: baseline_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 0: capture
  logic                            v0_r;
  logic [sdr_pkg::COORD_IN_W-1:0]  col0_r, row0_r;
  logic [sdr_pkg::DISP_W-1:0]      disp0_r;
  logic                            v0_nxt;

  // positive disparity only
  assign v0_nxt = in_acc && !in_disparity[sdr_pkg::DISP_W-1] && (in_disparity != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= v0_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col0_r  <= in_column & CMASK;
      row0_r  <= in_row & CMASK;
      disp0_r <= in_disparity;
    end
  end

  // stage 1: offsets, denominator, scale
  logic [CW-1:0] pos_x, pos_y;
  assign pos_x = {col0_r, 4'b0};
  assign pos_y = {row0_r, 4'b0};

  sdr_pkg::sdr_meta_t         meta1_r;
  logic [CW-1:0]              dxm1_r, dym1_r, fx1_r, fy1_r;
  logic [SCALE_W-1:0]         scale1_r;
  logic [sdr_pkg::DEN_W-1:0]  den1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) meta1_r <= '0;
    else if (en) begin
      meta1_r.v  <= v0_r;
      meta1_r.xn <= pos_x < center_x_r;
      meta1_r.yn <= pos_y < center_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxm1_r     <= (pos_x < center_x_r) ? center_x_r - pos_x : pos_x - center_x_r;
      dym1_r     <= (pos_y < center_y_r) ? center_y_r - pos_y : pos_y - center_y_r;
      fx1_r      <= (focal_x_r == '0) ? CW'(1) : focal_x_r;
      fy1_r      <= (focal_y_r == '0) ? CW'(1) : focal_y_r;
      scale1_r   <= SCALE_W'(baseline_r) << DISP_FRAC_BITS;
      den1_r     <= {disp0_r[sdr_pkg::DISP_W-2:0], 4'b0};
    end
  end

  // stage 2: first products
  sdr_pkg::sdr_meta_t          meta2_r;
  logic [NUMZ_W-1:0]           num_z2_r, num_x2_r, py2_r;
  logic [CW-1:0]               fx2_r;
  logic [sdr_pkg::DEN_W-1:0]   den2_r;
  logic [sdr_pkg::DENY_W-1:0]  deny2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) meta2_r <= '0;
    else if (en) meta2_r <= meta1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_z2_r   <= NUMZ_W'(scale1_r) * NUMZ_W'(fx1_r);
      num_x2_r   <= NUMZ_W'(dxm1_r) * NUMZ_W'(scale1_r);
      py2_r      <= NUMZ_W'(dym1_r) * NUMZ_W'(scale1_r);
      fx2_r      <= fx1_r;
      den2_r     <= den1_r;
      deny2_r    <= sdr_pkg::DENY_W'(den1_r) * sdr_pkg::DENY_W'(fy1_r);
    end
  end

  // stage 3: vertical numerator
  always_ff @(posedge clk) begin
    if (!rst_n) meta_o <= '0;
    else if (en) meta_o <= meta2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_z_o   <= num_z2_r;
      num_x_o   <= num_x2_r;
      num_y_o   <= NUMY_W'(py2_r) * NUMY_W'(fx2_r);
      den_o     <= den2_r;
      den_y_o   <= deny2_r;
    end
  end

endmodule
`default_nettype wire

>>> src/sdr_div.sv
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, 32-bit quotient
// plus an overflow flag when the true quotient needs more than 32 bits.
module sdr_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 19
) (
  input  wire                      clk,
  input  wire                      en,
  input  wire  [NUM_W-1:0]         num,
  input  wire  [DEN_W-1:0]         den,
  output logic [sdr_pkg::Q_W-1:0]  q_o,
  output logic                     ovf_o
);

  localparam int QW    = sdr_pkg::Q_W;
  localparam int HI_W  = NUM_W + 1 - QW;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [NUM_W:0]  num_ext;
  logic [HI_W-1:0] hi;
  assign num_ext = {1'b0, num};
  assign hi      = num_ext[NUM_W:QW];

  logic [DEN_W-1:0] rem_r [0:QW-1];
  logic [QW-1:0]    lo_r  [0:QW-1];
  logic [DEN_W-1:0] den_r [0:QW-1];
  logic [QW-1:0]    q_r   [0:QW];
  logic             ovf_r [0:QW];

  // entry stage: high part is the starting remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DEN_W'(hi);
      lo_r[0]  <= num[QW-1:0];
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= CMP_W'(hi) >= CMP_W'(den);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stg
    logic [DEN_W:0] t;
    logic           ge;
    assign t  = {rem_r[k-1], lo_r[k-1][QW-1]};
    assign ge = t >= {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= {q_r[k-1][QW-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? DEN_W'(t - {1'b0, den_r[k-1]}) : DEN_W'(t);
          lo_r[k]  <= {lo_r[k-1][QW-2:0], 1'b0};
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign q_o   = q_r[QW];
  assign ovf_o = ovf_r[QW];

endmodule
`default_nettype wire

>>> src/sdr_outbuf.sv
`default_nettype none
`include "assert_macros.svh"
// Saturation, output register and skid stage; drives the pipeline enable.
module sdr_outbuf (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  sdr_pkg::sdr_meta_t                    meta,
  input  wire  [sdr_pkg::Q_W-1:0]               q_z,
  input  wire                                   ovf_z,
  input  wire  [sdr_pkg::Q_W-1:0]               q_x,
  input  wire                                   ovf_x,
  input  wire  [sdr_pkg::Q_W-1:0]               q_y,
  input  wire                                   ovf_y,
  output logic                                  en_o,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [sdr_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  localparam int OW = sdr_pkg::OUT_TDATA_W;
  localparam int PW = sdr_pkg::PX_W;

  function automatic logic [PW-1:0] sat_s(input logic neg, input logic ovf,
                                          input logic [PW-1:0] q);
    logic big;
    big = ovf || q[PW-1];
    if (neg) sat_s = big ? {1'b1, {(PW-1){1'b0}}} : PW'(-q);
    else     sat_s = big ? {1'b0, {(PW-1){1'b1}}} : q;
  endfunction

  logic [sdr_pkg::PZ_W-1:0] pz;
  logic [OW-1:0]            res;
  assign pz  = (ovf_z || q_z[PW-1]) ? '1 : q_z[sdr_pkg::PZ_W-1:0];
  assign res = {1'b0, pz, sat_s(meta.yn, ovf_y, q_y), sat_s(meta.xn, ovf_x, q_x)};

  logic          out_v_r, skid_v_r;
  logic [OW-1:0] out_d_r, skid_d_r;
  logic          push;

  assign en_o = !skid_v_r;
  assign push = en_o && meta.v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) out_d_r <= skid_v_r ? skid_d_r : res;
    else if (push)              skid_d_r <= res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  `ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r)
  `ASSERT_NXT(a_stall_fills_skid, clk, rst_n, out_v_r && !out_tready && push, skid_v_r)
  `ASSERT_NXT(a_drain_skid, clk, rst_n, skid_v_r && out_tready, !skid_v_r && out_v_r)

endmodule
`default_nettype wire

>>> src/stereo_disparity_reprojection_top.sv
`default_nettype none
// Disparity-to-point reprojection (pinhole model). Each input word is one
// pixel {column, row, disparity Q.4}; a pixel with positive disparity yields
// one output word {point_x, point_y, point_z} in Q16.16 metres, rounded
// toward zero and saturated; zero or negative disparity yields nothing.
// Throughput is one word per clock while in_tready is high. There are
// 38 register stages, the first (capture) loaded at the accepting
// edge: 4 prep stages (capture, offsets, two multiply levels), 33
// stages of the bit-per-stage dividers, and the output register. A skid
// stage behind the output register lets the input keep going for one word
// after the output stalls; in_tready drops only while that stage is full.
// Config writes (focal_x, focal_y, center_x, center_y, stereo_baseline at
// indices 0..4) should be made with no word in flight; other indices are
// ignored. A zero focal length is treated as 1.
module stereo_disparity_reprojection_top #(
  parameter int COORD_WIDTH    = sdr_pkg::DEF_COORD_WIDTH,
  parameter int DISP_FRAC_BITS = sdr_pkg::DEF_DISP_FRAC_BITS
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wr_en,
  input  wire  [sdr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [sdr_pkg::CFG_W-1:0]           cfg_wdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [11:0] column, [23:12] row, [39:24] disparity
  input  wire  [sdr_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [31:0] point_x, [63:32] point_y, [94:64] point_z, [95] zero
  output logic [sdr_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int SCALE_W = sdr_pkg::CFG_W + DISP_FRAC_BITS;
  localparam int NUMZ_W  = SCALE_W + sdr_pkg::CFG_W;
  localparam int NUMY_W  = SCALE_W + 2 * sdr_pkg::CFG_W;
  localparam int DIV_LAT = sdr_pkg::Q_W + 1;

  logic en;
  logic in_acc;
  assign in_tready = en;
  assign in_acc    = in_tvalid && in_tready;

  sdr_pkg::sdr_meta_t         meta3;
  logic [NUMZ_W-1:0]          num_z, num_x;
  logic [NUMY_W-1:0]          num_y;
  logic [sdr_pkg::DEN_W-1:0]  den;
  logic [sdr_pkg::DENY_W-1:0] den_y;

  sdr_prep #(
    .COORD_WIDTH    (COORD_WIDTH),
    .DISP_FRAC_BITS (DISP_FRAC_BITS),
    .SCALE_W        (SCALE_W),
    .NUMZ_W         (NUMZ_W),
    .NUMY_W         (NUMY_W)
  ) u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_acc       (in_acc),
    .in_column    (in_tdata[11:0]),
    .in_row       (in_tdata[23:12]),
    .in_disparity (in_tdata[39:24]),
    .meta_o       (meta3),
    .num_z_o      (num_z),
    .num_x_o      (num_x),
    .num_y_o      (num_y),
    .den_o        (den),
    .den_y_o      (den_y)
  );

  // three dividers in lockstep: depth, lateral, vertical
  logic [sdr_pkg::Q_W-1:0] q_z, q_x, q_y;
  logic                    ovf_z, ovf_x, ovf_y;

  sdr_div #(.NUM_W(NUMZ_W), .DEN_W(sdr_pkg::DEN_W)) u_div_z (
    .clk(clk), .en(en), .num(num_z), .den(den), .q_o(q_z), .ovf_o(ovf_z)
  );

  sdr_div #(.NUM_W(NUMZ_W), .DEN_W(sdr_pkg::DEN_W)) u_div_x (
    .clk(clk), .en(en), .num(num_x), .den(den), .q_o(q_x), .ovf_o(ovf_x)
  );

  sdr_div #(.NUM_W(NUMY_W), .DEN_W(sdr_pkg::DENY_W)) u_div_y (
    .clk(clk), .en(en), .num(num_y), .den(den_y), .q_o(q_y), .ovf_o(ovf_y)
  );

  // valid bit and signs follow the divider stages
  sdr_pkg::sdr_meta_t meta_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) meta_r[i] <= '0;
    end else if (en) begin
      meta_r[0] <= meta3;
      for (int i = 1; i < DIV_LAT; i++) meta_r[i] <= meta_r[i-1];
    end
  end

  sdr_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .meta       (meta_r[DIV_LAT-1]),
    .q_z        (q_z),
    .ovf_z      (ovf_z),
    .q_x        (q_x),
    .ovf_x      (ovf_x),
    .q_y        (q_y),
    .ovf_y      (ovf_y),
    .en_o       (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
